### hdl/egg_drop_min_trials_unit_macros.svh
// Assertion helpers shared by the egg drop unit.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef EGG_DROP_MIN_TRIALS_UNIT_MACROS_SVH
`define EGG_DROP_MIN_TRIALS_UNIT_MACROS_SVH

// Same-cycle implication
`define EDMT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("edmt assertion failed");

// Next-cycle implication
`define EDMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("edmt assertion failed");

`endif

### hdl/edmt_pkg.sv
// ----------------------------------------------------------------------------
// edmt_pkg
// Shared constants of the egg drop minimum trials unit.
// ----------------------------------------------------------------------------
package edmt_pkg;

  // Default sizes
  localparam int DEF_MAX_EGGS   = 16;
  localparam int DEF_MAX_FLOORS = 1024;

  // Fixed port widths
  localparam int EGG_IN_W  = 16;
  localparam int FLOOR_W   = 11;

  // Width of a count that can hold the given floor limit, never under FLOOR_W
  function automatic int count_width(input int max_floors);
    int w;
    w = $clog2(max_floors + 1);
    return (w > FLOOR_W) ? w : FLOOR_W;
  endfunction

endpackage

### hdl/edmt_ram.sv
// ----------------------------------------------------------------------------
// edmt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module edmt_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 17,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/edmt_update.sv
// ----------------------------------------------------------------------------
// edmt_update
// Shared update unit: saturating count step and coverage compare.
// ----------------------------------------------------------------------------
module edmt_update #(
  parameter int MAX_FLOORS = edmt_pkg::DEF_MAX_FLOORS,
  parameter int VW         = edmt_pkg::count_width(MAX_FLOORS)
) (
  input  logic [VW-1:0] old_val,
  input  logic [VW-1:0] prev_val,
  input  logic [VW-1:0] floors,
  output logic [VW-1:0] new_val,
  output logic          covered
);

  logic [VW+1:0] sum;

  // new = old + prev + 1, clipped at the floor limit
  always_comb begin
    sum     = {2'b00, old_val} + {2'b00, prev_val} + (VW+2)'(1);
    new_val = (sum > (VW+2)'(MAX_FLOORS)) ? VW'(MAX_FLOORS) : sum[VW-1:0];
    covered = (new_val >= floors);
  end

endmodule

### hdl/egg_drop_min_trials_unit.sv
// ----------------------------------------------------------------------------
// egg_drop_min_trials_unit
// Least worst-case drop count for a given egg and floor count.
// ----------------------------------------------------------------------------
// Channel  Direction  Ports                               Transfer
// input    in         start, in_egg_count, in_floor_count start && !busy
// result   out        out_valid, out_min_drops, out_invalid  out_valid (1 cycle)
//
// Zero or one floor, zero or one egg: result strobes in the cycle after start.
// Otherwise with E clamped eggs and result D: the sequencer clears count RAM
// entries 1..E, then D rounds of read/update over entries 1..E through the count
// RAM and the shared update unit; the result strobes in the cycle after the last update.
// On a table run busy is high from the cycle after start until the result
// strobes; the short cases never raise busy.
// Reset clears the sequencer only; each table run clears the count RAM itself.
// The result strobe cannot be stalled.
`include "egg_drop_min_trials_unit_macros.svh"

module egg_drop_min_trials_unit #(
  parameter int MAX_EGGS   = edmt_pkg::DEF_MAX_EGGS,
  parameter int MAX_FLOORS = edmt_pkg::DEF_MAX_FLOORS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [edmt_pkg::EGG_IN_W-1:0] in_egg_count,
  input  logic [edmt_pkg::FLOOR_W-1:0]  in_floor_count,
  output logic                         out_valid,
  output logic [edmt_pkg::FLOOR_W-1:0]  out_min_drops,
  output logic                         out_invalid
);

  localparam int VW    = edmt_pkg::count_width(MAX_FLOORS);
  localparam int DEPTH = MAX_EGGS + 1;
  localparam int EW    = $clog2(DEPTH);
  localparam int FW    = edmt_pkg::FLOOR_W;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CLR  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [EW-1:0] e_r, e_nxt;
  logic [EW-1:0] eggs_r, eggs_nxt;
  logic [VW-1:0] floors_r, floors_nxt;
  logic [VW-1:0] prev_r, prev_nxt;
  logic [FW-1:0] drops_r, drops_nxt;
  logic          valid_r, valid_nxt;
  logic [FW-1:0] res_r, res_nxt;
  logic          bad_r, bad_nxt;

  logic [EW-1:0] eggs_cl;
  logic [VW-1:0] floors_cl;
  logic          accept;

  logic          ram_we;
  logic [VW-1:0] ram_wdata;
  logic [VW-1:0] ram_rdata;
  logic [VW-1:0] upd_val;
  logic          upd_covered;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Input clamping
  always_comb begin
    eggs_cl   = (in_egg_count > edmt_pkg::EGG_IN_W'(MAX_EGGS)) ? EW'(MAX_EGGS)
                                                               : in_egg_count[EW-1:0];
    floors_cl = (VW'(in_floor_count) > VW'(MAX_FLOORS)) ? VW'(MAX_FLOORS)
                                                        : VW'(in_floor_count);
  end

  // Count RAM, one entry per egg count
  edmt_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH),
    .AW    (EW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (e_r),
    .wdata (ram_wdata),
    .raddr (e_r),
    .rdata (ram_rdata)
  );

  // Shared update unit
  edmt_update #(
    .MAX_FLOORS (MAX_FLOORS),
    .VW         (VW)
  ) u_update (
    .old_val  (ram_rdata),
    .prev_val (prev_r),
    .floors   (floors_r),
    .new_val  (upd_val),
    .covered  (upd_covered)
  );

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    e_nxt      = e_r;
    eggs_nxt   = eggs_r;
    floors_nxt = floors_r;
    prev_nxt   = prev_r;
    drops_nxt  = drops_r;
    valid_nxt  = 1'b0;
    res_nxt    = res_r;
    bad_nxt    = bad_r;
    ram_we     = 1'b0;
    ram_wdata  = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          eggs_nxt   = eggs_cl;
          floors_nxt = floors_cl;
          if (floors_cl <= VW'(1)) begin
            valid_nxt = 1'b1;
            res_nxt   = floors_cl[FW-1:0];
            bad_nxt   = 1'b0;
          end else if (eggs_cl == '0) begin
            valid_nxt = 1'b1;
            res_nxt   = '0;
            bad_nxt   = 1'b1;
          end else if (eggs_cl == EW'(1)) begin
            valid_nxt = 1'b1;
            res_nxt   = floors_cl[FW-1:0];
            bad_nxt   = 1'b0;
          end else begin
            state_nxt = S_CLR;
            e_nxt     = EW'(1);
            drops_nxt = '0;
          end
        end
      end
      S_CLR: begin
        // zero entries 1..eggs
        ram_we = 1'b1;
        if (e_r == eggs_r) begin
          state_nxt = S_RD;
          e_nxt     = EW'(1);
          prev_nxt  = '0;
        end else begin
          e_nxt = e_r + EW'(1);
        end
      end
      S_RD: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        // entry e takes old[e] + old[e-1] + 1, upward order keeps old[e-1]
        ram_we    = 1'b1;
        ram_wdata = upd_val;
        prev_nxt  = ram_rdata;
        if (e_r == eggs_r) begin
          drops_nxt = drops_r + FW'(1);
          if (upd_covered) begin
            state_nxt = S_IDLE;
            valid_nxt = 1'b1;
            res_nxt   = drops_r + FW'(1);
            bad_nxt   = 1'b0;
          end else begin
            state_nxt = S_RD;
            e_nxt     = EW'(1);
            prev_nxt  = '0;
          end
        end else begin
          state_nxt = S_RD;
          e_nxt     = e_r + EW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    e_r      <= e_nxt;
    eggs_r   <= eggs_nxt;
    floors_r <= floors_nxt;
    prev_r   <= prev_nxt;
    drops_r  <= drops_nxt;
    res_r    <= res_nxt;
    bad_r    <= bad_nxt;
  end

  assign out_valid     = valid_r;
  assign out_min_drops = res_r;
  assign out_invalid   = bad_r;

  // Checks
  `EDMT_ASSERT_SAME(a_invalid_zero, out_valid && out_invalid, out_min_drops == '0)
  `EDMT_ASSERT_SAME(a_drops_bound, state_r != S_IDLE, VW'(drops_r) < floors_r)
  `EDMT_ASSERT_SAME(a_index_range, state_r == S_UPD, (e_r != '0) && (e_r <= eggs_r))
  `EDMT_ASSERT_NEXT(a_trivial_floor, accept && (in_floor_count <= FW'(1)),
                    out_valid && (out_min_drops == $past(in_floor_count)))

endmodule

### bench/tb_egg_drop_min_trials_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_egg_drop_min_trials_unit
// Self-checking bench for the egg drop minimum trials unit.
// Requests go in through the start/busy command port. Each accepted request
// is solved by a local copy of the floor-coverage count, and each result
// strobe is compared against the oldest pending answer. A directed set hits
// the edge cases, then random requests run under several sender idle mixes.
// ----------------------------------------------------------------------------
module tb_egg_drop_min_trials_unit;

  localparam int EGG_LIMIT   = edmt_pkg::DEF_MAX_EGGS;
  localparam int FLOOR_LIMIT = edmt_pkg::DEF_MAX_FLOORS;
  localparam int CLK_HALF    = 6;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 400;
  localparam int RAND_ITEMS  = 100;
  localparam int NUM_PHASES  = 4;

  typedef struct packed {
    logic [edmt_pkg::FLOOR_W-1:0] min_drops;
    logic                         invalid;
  } drop_answer_t;

  // --------------------------------------------------------------------------
  // Answer tracking
  // --------------------------------------------------------------------------
  class drop_scoreboard;
    drop_answer_t pending_answers[$];
    int           fail_count;

    function new();
      fail_count = 0;
    endfunction

    // Least t such that t drops with the given eggs cover all floors
    function drop_answer_t solve_drops(logic [edmt_pkg::EGG_IN_W-1:0] eggs_in,
                                       logic [edmt_pkg::FLOOR_W-1:0] floors_in);
      drop_answer_t ans;
      int eggs;
      int floors;
      int drops;
      int sum;
      int covered[EGG_LIMIT+1];
      floors = (floors_in > FLOOR_LIMIT) ? FLOOR_LIMIT : int'(floors_in);
      eggs   = (eggs_in > EGG_LIMIT) ? EGG_LIMIT : int'(eggs_in);
      ans.invalid = 1'b0;
      if (floors <= 1) begin
        drops = floors;
      end else if (eggs == 0) begin
        drops = 0;
        ans.invalid = 1'b1;
      end else if (eggs == 1) begin
        drops = floors;
      end else begin
        drops = 0;
        for (int e = 0; e <= EGG_LIMIT; e++) covered[e] = 0;
        while (covered[eggs] < floors) begin
          drops++;
          // walk down so each entry still sees last round's lower neighbor
          for (int e = eggs; e >= 1; e--) begin
            sum = covered[e] + covered[e-1] + 1;
            covered[e] = (sum > FLOOR_LIMIT) ? FLOOR_LIMIT : sum;
          end
        end
      end
      ans.min_drops = drops[edmt_pkg::FLOOR_W-1:0];
      return ans;
    endfunction

    function void note_request(logic [edmt_pkg::EGG_IN_W-1:0] eggs,
                               logic [edmt_pkg::FLOOR_W-1:0] floors);
      pending_answers.push_back(solve_drops(eggs, floors));
    endfunction

    function void check_result(logic [edmt_pkg::FLOOR_W-1:0] drops, logic invalid);
      drop_answer_t exp_ans;
      if (pending_answers.size() == 0) begin
        $error("result with nothing pending: min_drops=%0d invalid=%0d", drops, invalid);
        fail_count++;
        return;
      end
      exp_ans = pending_answers.pop_front();
      if (drops !== exp_ans.min_drops) begin
        $error("min_drops mismatch: expected %0d, actual %0d", exp_ans.min_drops, drops);
        fail_count++;
      end
      if (invalid !== exp_ans.invalid) begin
        $error("invalid mismatch: expected %0d, actual %0d", exp_ans.invalid, invalid);
        fail_count++;
      end
    endfunction

    function int outstanding();
      return pending_answers.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [edmt_pkg::EGG_IN_W-1:0] in_egg_count;
  logic [edmt_pkg::FLOOR_W-1:0]  in_floor_count;
  logic                          out_valid;
  logic [edmt_pkg::FLOOR_W-1:0]  out_min_drops;
  logic                          out_invalid;

  drop_scoreboard sb = new();
  int             stall_cycles;
  int             idle_pct;

  egg_drop_min_trials_unit #(
    .MAX_EGGS   (EGG_LIMIT),
    .MAX_FLOORS (FLOOR_LIMIT)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_egg_count   (in_egg_count),
    .in_floor_count (in_floor_count),
    .out_valid      (out_valid),
    .out_min_drops  (out_min_drops),
    .out_invalid    (out_invalid)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Monitor: request transfers and result strobes, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_egg_count, in_floor_count);
      if (out_valid) sb.check_result(out_min_drops, out_invalid);
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one request from a falling edge and hold it until it transfers
  task automatic send_request(input logic [edmt_pkg::EGG_IN_W-1:0] eggs,
                              input logic [edmt_pkg::FLOOR_W-1:0] floors);
    start          <= 1'b1;
    in_egg_count   <= eggs;
    in_floor_count <= floors;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drop start for a few cycles, with junk on the fields
  task automatic sender_gap(input int cycles);
    start          <= 1'b0;
    in_egg_count   <= 16'($urandom);
    in_floor_count <= 11'($urandom);
    repeat (cycles) @(negedge clk);
  endtask

  // Hold off until every pending answer has been returned
  task automatic drain_answers();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Random request, mostly well-formed multi-egg cases
  task automatic send_random();
    int sel;
    logic [edmt_pkg::EGG_IN_W-1:0] eggs;
    logic [edmt_pkg::FLOOR_W-1:0]  floors;
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      eggs   = 16'($urandom_range(2, EGG_LIMIT));
      floors = 11'($urandom_range(2, FLOOR_LIMIT));
    end else if (sel < 75) begin
      eggs   = 16'($urandom_range(0, 1));
      floors = 11'($urandom);
    end else if (sel < 85) begin
      eggs   = 16'($urandom_range(EGG_LIMIT + 1, 65535));
      floors = 11'($urandom);
    end else if (sel < 92) begin
      eggs   = 16'($urandom);
      floors = 11'($urandom_range(0, 1));
    end else begin
      eggs   = 16'($urandom_range(0, 20));
      floors = 11'($urandom_range(FLOOR_LIMIT + 1, 2047));
    end
    send_request(eggs, floors);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) sender_gap($urandom_range(1, 6));
  endtask

  // Stimulus
  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_egg_count   = '0;
    in_floor_count = '0;
    idle_pct       = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed edge cases: empty and single floor, no eggs, one egg,
    // egg clamp, floor saturation, full-width fields
    send_request(16'd0, 11'd0);
    send_request(16'd0, 11'd1);
    send_request(16'd0, 11'd2);
    send_request(16'd0, 11'd1024);
    send_request(16'd0, 11'd2047);
    send_request(16'd1, 11'd0);
    send_request(16'd1, 11'd1);
    send_request(16'd1, 11'd2);
    send_request(16'd1, 11'd1024);
    send_request(16'd2, 11'd2);
    send_request(16'd2, 11'd36);
    send_request(16'd2, 11'd100);
    send_request(16'd2, 11'd1024);
    send_request(16'd16, 11'd3);
    send_request(16'd16, 11'd1024);
    send_request(16'd17, 11'd1024);
    send_request(16'd3, 11'd1025);
    send_request(16'd65535, 11'd2047);
    send_request(16'd65535, 11'd0);
    send_request(16'd65535, 11'd1);
    drain_answers();

    // Random requests across idle mixes; the result side cannot stall
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 56;
        2: idle_pct = 0;
        default: idle_pct = 27;
      endcase
      for (int n = 0; n < RAND_ITEMS / NUM_PHASES; n++) send_random();
      drain_answers();
    end

    // Let any late strobe show up before closing out
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
